>>> design/chgsup_pkg.sv
package chgsup_pkg;

   // Result action codes
   typedef enum logic [1:0] {
      ACT_WRITE   = 2'd0,
      ACT_DISABLE = 2'd1,
      ACT_ENABLE  = 2'd2,
      ACT_PULSE   = 2'd3
   } action_type;

   // Charger register selects
   typedef enum logic [1:0] {
      SEL_INPUT_SOURCE   = 2'd0,
      SEL_CHARGE_CURRENT = 2'd1,
      SEL_TERMINATION    = 2'd2,
      SEL_MISC           = 2'd3
   } sel_type;

   // Configuration register indexes
   typedef enum logic [2:0] {
      CSR_DC_THRESHOLD   = 3'd0,
      CSR_USB_THRESHOLD  = 3'd1,
      CSR_TEMP_OFF_LIMIT = 3'd2,
      CSR_TEMP_ON_LIMIT  = 3'd3,
      CSR_DEBOUNCE_MS    = 3'd4,
      CSR_LIMIT_INTERVAL = 3'd5
   } csr_index_type;

   localparam int CSR_ADDR_W = 5;

   // Register byte values
   localparam logic [7:0] SRC_SETUP   = 8'b0011_0000;
   localparam logic [7:0] CUR_SETUP   = 8'b0010_0000;
   localparam logic [7:0] TERM_SETUP  = 8'b1000_1010;
   localparam logic [7:0] MISC_SETUP  = 8'b1100_1000;
   localparam logic [7:0] SRC_LIMIT   = 8'b0011_0111;
   localparam logic [2:0] SRC_ALL_SET = 3'b111;
   localparam logic [2:0] SRC_NONE    = 3'b000;

   // Configuration reset values
   localparam logic signed [15:0] TEMP_OFF_RESET = 16'sd6000;
   localparam logic signed [15:0] TEMP_ON_RESET  = 16'sd4500;
   localparam logic [15:0] DEBOUNCE_RESET        = 16'd500;
   localparam logic [15:0] LIMIT_INTERVAL_RESET  = 16'd500;

   // Result slots of one pass, in delivery order
   localparam int NUM_SLOTS = 8;
   localparam int SLOT_W    = 3;
   localparam logic [SLOT_W-1:0] SLOT_SRC_SETUP  = 3'd0;
   localparam logic [SLOT_W-1:0] SLOT_CUR_SETUP  = 3'd1;
   localparam logic [SLOT_W-1:0] SLOT_TERM_SETUP = 3'd2;
   localparam logic [SLOT_W-1:0] SLOT_MISC_SETUP = 3'd3;
   localparam logic [SLOT_W-1:0] SLOT_TEMP       = 3'd4;
   localparam logic [SLOT_W-1:0] SLOT_LIMIT      = 3'd5;
   localparam logic [SLOT_W-1:0] SLOT_USB        = 3'd6;
   localparam logic [SLOT_W-1:0] SLOT_DC         = 3'd7;

   typedef struct packed {
      logic [15:0]        dc_threshold;
      logic [15:0]        usb_threshold;
      logic signed [15:0] temp_off_limit;
      logic signed [15:0] temp_on_limit;
      logic [15:0]        debounce_ms;
      logic [15:0]        limit_interval_ms;
   } cfg_type;

   typedef struct packed {
      logic                 load;
      logic [NUM_SLOTS-1:0] mask;
      action_type           temp_action;
      sel_type              limit_sel;
      logic [7:0]           limit_value;
   } pass_type;

   // Wrap-safe time check
   function automatic logic elapsed(input logic [31:0] now, input logic [31:0] stamp,
                                    input logic [15:0] dur);
      logic [31:0] diff;
      diff = now - stamp;
      return diff >= {16'b0, dur};
   endfunction

endpackage

>>> design/chgsup_req_if.sv
interface chgsup_req_if;
   logic               valid;
   logic               ready;
   logic [31:0]        now_ms;
   logic [15:0]        usb_sample;
   logic [15:0]        dc_sample;
   logic signed [15:0] battery_temp;
   logic               battery_present;
   logic [7:0]         source_reg_value;
   logic               source_reg_valid;

   modport source(output valid, now_ms, usb_sample, dc_sample, battery_temp,
                  battery_present, source_reg_value, source_reg_valid, input ready);
   modport sink(input valid, now_ms, usb_sample, dc_sample, battery_temp,
                battery_present, source_reg_value, source_reg_valid, output ready);
endinterface

>>> design/chgsup_rsp_if.sv
interface chgsup_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic [1:0] reg_select;
   logic [7:0] reg_value;
   logic       last;

   modport source(output valid, action, reg_select, reg_value, last, input ready);
   modport sink(input valid, action, reg_select, reg_value, last, output ready);
endinterface

>>> design/chgsup_csr.sv
module chgsup_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [chgsup_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [31:0]                        pwdata,
   output logic [31:0]                        prdata,
   output logic                               pready,
   output chgsup_pkg::cfg_type                cfg
);

   chgsup_pkg::cfg_type       cfg_ff, cfg_in;
   chgsup_pkg::csr_index_type index;
   logic                      write_en;

   assign pready   = 1'b1;
   assign index    = chgsup_pkg::csr_index_type'(paddr[chgsup_pkg::CSR_ADDR_W-1:2]);
   assign write_en = psel & penable & pwrite & pready;
   assign cfg      = cfg_ff;

   // Apply a register write
   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (index)
            chgsup_pkg::CSR_DC_THRESHOLD:   cfg_in.dc_threshold      = pwdata[15:0];
            chgsup_pkg::CSR_USB_THRESHOLD:  cfg_in.usb_threshold     = pwdata[15:0];
            chgsup_pkg::CSR_TEMP_OFF_LIMIT: cfg_in.temp_off_limit    = pwdata[15:0];
            chgsup_pkg::CSR_TEMP_ON_LIMIT:  cfg_in.temp_on_limit     = pwdata[15:0];
            chgsup_pkg::CSR_DEBOUNCE_MS:    cfg_in.debounce_ms       = pwdata[15:0];
            chgsup_pkg::CSR_LIMIT_INTERVAL: cfg_in.limit_interval_ms = pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dc_threshold      <= '0;
         cfg_ff.usb_threshold     <= '0;
         cfg_ff.temp_off_limit    <= chgsup_pkg::TEMP_OFF_RESET;
         cfg_ff.temp_on_limit     <= chgsup_pkg::TEMP_ON_RESET;
         cfg_ff.debounce_ms       <= chgsup_pkg::DEBOUNCE_RESET;
         cfg_ff.limit_interval_ms <= chgsup_pkg::LIMIT_INTERVAL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back a register
   always_comb begin
      case (index)
         chgsup_pkg::CSR_DC_THRESHOLD:   prdata = {16'b0, cfg_ff.dc_threshold};
         chgsup_pkg::CSR_USB_THRESHOLD:  prdata = {16'b0, cfg_ff.usb_threshold};
         chgsup_pkg::CSR_TEMP_OFF_LIMIT: prdata = {16'b0, cfg_ff.temp_off_limit};
         chgsup_pkg::CSR_TEMP_ON_LIMIT:  prdata = {16'b0, cfg_ff.temp_on_limit};
         chgsup_pkg::CSR_DEBOUNCE_MS:    prdata = {16'b0, cfg_ff.debounce_ms};
         chgsup_pkg::CSR_LIMIT_INTERVAL: prdata = {16'b0, cfg_ff.limit_interval_ms};
         default:                        prdata = '0;
      endcase
   end

endmodule

>>> design/chgsup_pass.sv
module chgsup_pass (
   input  logic                 clock,
   input  logic                 reset,
   chgsup_req_if.sink           req_bus,
   input  chgsup_pkg::cfg_type  cfg,
   input  logic                 free,
   output chgsup_pkg::pass_type pass
);

   // Input register
   logic               in_valid_ff, in_valid_in;
   logic [31:0]        in_now_ff;
   logic [15:0]        in_usb_ff;
   logic [15:0]        in_dc_ff;
   logic signed [15:0] in_temp_ff;
   logic               in_batt_ff;
   logic [7:0]         in_src_ff;
   logic               in_src_ok_ff;

   // Supervisor state
   logic        setup_done_ff, setup_done_in;
   logic        charge_on_ff, charge_on_in;
   logic [15:0] prev_dc_ff, prev_dc_in;
   logic [31:0] limit_stamp_ff, limit_stamp_in;
   logic        usb_was_low_ff, usb_was_low_in;
   logic [31:0] usb_stamp_ff, usb_stamp_in;
   logic        dc_was_low_ff, dc_was_low_in;
   logic [31:0] dc_stamp_ff, dc_stamp_in;
   logic [31:0] lockout_ff, lockout_in;

   logic accept, advance;
   logic usb_on, dc_on, charge_mid, temp_ok, lock_free;
   logic [chgsup_pkg::NUM_SLOTS-1:0] mask;
   chgsup_pkg::action_type           temp_action;
   chgsup_pkg::sel_type              limit_sel;
   logic [7:0]                       limit_value;

   assign advance       = in_valid_ff & free;
   assign req_bus.ready = ~in_valid_ff | free;
   assign accept        = req_bus.valid & req_bus.ready;
   assign in_valid_in   = accept | (in_valid_ff & ~free);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // Capture the item
   always_ff @(posedge clock) begin
      if (accept) begin
         in_now_ff    <= req_bus.now_ms;
         in_usb_ff    <= req_bus.usb_sample;
         in_dc_ff     <= req_bus.dc_sample;
         in_temp_ff   <= req_bus.battery_temp;
         in_batt_ff   <= req_bus.battery_present;
         in_src_ff    <= req_bus.source_reg_value;
         in_src_ok_ff <= req_bus.source_reg_valid;
      end
   end

   assign usb_on = in_usb_ff > cfg.usb_threshold;
   assign dc_on  = in_dc_ff > cfg.dc_threshold;

   // One supervisor pass
   always_comb begin
      mask           = '0;
      temp_action    = chgsup_pkg::ACT_DISABLE;
      limit_sel      = chgsup_pkg::SEL_INPUT_SOURCE;
      limit_value    = chgsup_pkg::SRC_LIMIT;
      setup_done_in  = setup_done_ff;
      charge_mid     = charge_on_ff;
      prev_dc_in     = prev_dc_ff;
      limit_stamp_in = limit_stamp_ff;
      usb_was_low_in = usb_was_low_ff;
      usb_stamp_in   = usb_stamp_ff;
      dc_was_low_in  = dc_was_low_ff;
      dc_stamp_in    = dc_stamp_ff;
      lockout_in     = lockout_ff;

      // Set-up writes on the first pass
      if (!setup_done_ff) begin
         setup_done_in                        = 1'b1;
         mask[chgsup_pkg::SLOT_SRC_SETUP]  = 1'b1;
         mask[chgsup_pkg::SLOT_CUR_SETUP]  = 1'b1;
         mask[chgsup_pkg::SLOT_TERM_SETUP] = 1'b1;
         mask[chgsup_pkg::SLOT_MISC_SETUP] = 1'b1;
      end

      // Temperature hysteresis
      if (in_batt_ff) begin
         if (charge_on_ff) begin
            if (in_temp_ff > $signed(cfg.temp_off_limit)) begin
               charge_mid                  = 1'b0;
               mask[chgsup_pkg::SLOT_TEMP] = 1'b1;
               temp_action                 = chgsup_pkg::ACT_DISABLE;
            end
         end else if (in_temp_ff < $signed(cfg.temp_on_limit)) begin
            charge_mid                  = 1'b1;
            mask[chgsup_pkg::SLOT_TEMP] = 1'b1;
            temp_action                 = chgsup_pkg::ACT_ENABLE;
         end
      end

      // Input current limit step
      if (chgsup_pkg::elapsed(in_now_ff, limit_stamp_ff, cfg.limit_interval_ms)) begin
         limit_stamp_in = in_now_ff;
         if (in_src_ok_ff) begin
            if (prev_dc_ff > cfg.dc_threshold && in_dc_ff < cfg.dc_threshold && usb_on) begin
               mask[chgsup_pkg::SLOT_LIMIT] = 1'b1;
               limit_sel                    = chgsup_pkg::SEL_MISC;
               limit_value                  = chgsup_pkg::MISC_SETUP;
            end else if (dc_on) begin
               if (in_src_ff[2:0] != chgsup_pkg::SRC_ALL_SET) begin
                  mask[chgsup_pkg::SLOT_LIMIT] = 1'b1;
               end
            end else if (usb_on) begin
               if (in_src_ff[2:0] == chgsup_pkg::SRC_NONE) begin
                  mask[chgsup_pkg::SLOT_LIMIT] = 1'b1;
               end
            end
            prev_dc_in = in_dc_ff;
         end
      end

      // Supply debounce and lockout
      charge_on_in = charge_mid;
      temp_ok      = charge_mid ? (in_temp_ff < $signed(cfg.temp_off_limit))
                                : (in_temp_ff < $signed(cfg.temp_on_limit));
      lock_free    = (lockout_ff == '0) |
                     chgsup_pkg::elapsed(in_now_ff, lockout_ff, cfg.debounce_ms);
      if (in_batt_ff && temp_ok && lock_free) begin
         lockout_in = '0;
         if (usb_was_low_ff && usb_on) begin
            usb_was_low_in = 1'b0;
            usb_stamp_in   = in_now_ff;
         end else if (!usb_was_low_ff && usb_on && usb_stamp_ff != '0) begin
            if (chgsup_pkg::elapsed(in_now_ff, usb_stamp_ff, cfg.debounce_ms)) begin
               usb_stamp_in               = '0;
               mask[chgsup_pkg::SLOT_USB] = 1'b1;
               charge_on_in               = 1'b1;
            end
         end else if (!usb_was_low_ff && !usb_on) begin
            usb_was_low_in = 1'b1;
            usb_stamp_in   = '0;
            lockout_in     = in_now_ff;
         end
         if (dc_was_low_ff && dc_on) begin
            dc_was_low_in = 1'b0;
            dc_stamp_in   = in_now_ff;
         end else if (!dc_was_low_ff && dc_on && dc_stamp_ff != '0) begin
            if (chgsup_pkg::elapsed(in_now_ff, dc_stamp_ff, cfg.debounce_ms)) begin
               dc_stamp_in               = '0;
               mask[chgsup_pkg::SLOT_DC] = 1'b1;
               charge_on_in              = 1'b1;
            end
         end else if (!dc_was_low_ff && !dc_on) begin
            dc_was_low_in = 1'b1;
            dc_stamp_in   = '0;
            lockout_in    = in_now_ff;
         end
      end
   end

   // Commit state when the pass moves on
   always_ff @(posedge clock) begin
      if (reset) begin
         setup_done_ff  <= 1'b0;
         charge_on_ff   <= 1'b0;
         prev_dc_ff     <= '0;
         limit_stamp_ff <= '0;
         usb_was_low_ff <= 1'b1;
         usb_stamp_ff   <= '0;
         dc_was_low_ff  <= 1'b1;
         dc_stamp_ff    <= '0;
         lockout_ff     <= '0;
      end else if (advance) begin
         setup_done_ff  <= setup_done_in;
         charge_on_ff   <= charge_on_in;
         prev_dc_ff     <= prev_dc_in;
         limit_stamp_ff <= limit_stamp_in;
         usb_was_low_ff <= usb_was_low_in;
         usb_stamp_ff   <= usb_stamp_in;
         dc_was_low_ff  <= dc_was_low_in;
         dc_stamp_ff    <= dc_stamp_in;
         lockout_ff     <= lockout_in;
      end
   end

   assign pass.load        = advance;
   assign pass.mask        = mask;
   assign pass.temp_action = temp_action;
   assign pass.limit_sel   = limit_sel;
   assign pass.limit_value = limit_value;

   a_setup_once: assert property (@(posedge clock) disable iff (reset)
      advance |=> setup_done_ff)
      else $error("set-up not marked done after a pass");

   a_pulse_charges: assert property (@(posedge clock) disable iff (reset)
      (advance && (mask[chgsup_pkg::SLOT_USB] || mask[chgsup_pkg::SLOT_DC]))
      |=> charge_on_ff)
      else $error("restart pulse without charging on");

   a_usb_stamp_idle: assert property (@(posedge clock) disable iff (reset)
      usb_was_low_ff |-> (usb_stamp_ff == '0))
      else $error("USB stamp set while USB low");

   a_dc_stamp_idle: assert property (@(posedge clock) disable iff (reset)
      dc_was_low_ff |-> (dc_stamp_ff == '0))
      else $error("DC stamp set while DC low");

endmodule

>>> design/chgsup_out.sv
module chgsup_out (
   input  logic                 clock,
   input  logic                 reset,
   input  chgsup_pkg::pass_type pass,
   output logic                 free,
   chgsup_rsp_if.source         rsp_bus
);

   logic [chgsup_pkg::NUM_SLOTS-1:0] mask_ff, mask_in, rest;
   chgsup_pkg::action_type           temp_action_ff;
   chgsup_pkg::sel_type              limit_sel_ff;
   logic [7:0]                       limit_value_ff;
   logic [chgsup_pkg::SLOT_W-1:0]    cur;
   logic                             take, is_last;

   // Pick the earliest pending slot
   always_comb begin
      cur = '0;
      for (int i = chgsup_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            cur = chgsup_pkg::SLOT_W'(i);
         end
      end
   end

   always_comb begin
      rest      = mask_ff;
      rest[cur] = 1'b0;
   end

   assign is_last = (rest == '0);
   assign take    = rsp_bus.valid & rsp_bus.ready;
   assign free    = (mask_ff == '0) | (take & is_last);

   // Load a new pass or drop the delivered slot
   always_comb begin
      mask_in = mask_ff;
      if (pass.load) begin
         mask_in = pass.mask;
      end else if (take) begin
         mask_in = rest;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else begin
         mask_ff <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pass.load) begin
         temp_action_ff <= pass.temp_action;
         limit_sel_ff   <= pass.limit_sel;
         limit_value_ff <= pass.limit_value;
      end
   end

   // Drive the current item
   always_comb begin
      rsp_bus.valid = (mask_ff != '0);
      rsp_bus.last  = is_last;
      case (cur)
         chgsup_pkg::SLOT_SRC_SETUP: begin
            rsp_bus.action     = chgsup_pkg::ACT_WRITE;
            rsp_bus.reg_select = chgsup_pkg::SEL_INPUT_SOURCE;
            rsp_bus.reg_value  = chgsup_pkg::SRC_SETUP;
         end
         chgsup_pkg::SLOT_CUR_SETUP: begin
            rsp_bus.action     = chgsup_pkg::ACT_WRITE;
            rsp_bus.reg_select = chgsup_pkg::SEL_CHARGE_CURRENT;
            rsp_bus.reg_value  = chgsup_pkg::CUR_SETUP;
         end
         chgsup_pkg::SLOT_TERM_SETUP: begin
            rsp_bus.action     = chgsup_pkg::ACT_WRITE;
            rsp_bus.reg_select = chgsup_pkg::SEL_TERMINATION;
            rsp_bus.reg_value  = chgsup_pkg::TERM_SETUP;
         end
         chgsup_pkg::SLOT_MISC_SETUP: begin
            rsp_bus.action     = chgsup_pkg::ACT_WRITE;
            rsp_bus.reg_select = chgsup_pkg::SEL_MISC;
            rsp_bus.reg_value  = chgsup_pkg::MISC_SETUP;
         end
         chgsup_pkg::SLOT_TEMP: begin
            rsp_bus.action     = temp_action_ff;
            rsp_bus.reg_select = chgsup_pkg::SEL_INPUT_SOURCE;
            rsp_bus.reg_value  = '0;
         end
         chgsup_pkg::SLOT_LIMIT: begin
            rsp_bus.action     = chgsup_pkg::ACT_WRITE;
            rsp_bus.reg_select = limit_sel_ff;
            rsp_bus.reg_value  = limit_value_ff;
         end
         default: begin
            rsp_bus.action     = chgsup_pkg::ACT_PULSE;
            rsp_bus.reg_select = chgsup_pkg::SEL_INPUT_SOURCE;
            rsp_bus.reg_value  = '0;
         end
      endcase
   end

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      pass.load |-> free)
      else $error("pass loaded over undelivered items");

endmodule

>>> design/charger_supervisor_core.sv
// Battery charger supervisor. Each request item is one supervisor pass; it
// yields zero to eight response items (charger register writes, charge
// disable/enable, restart pulse), the final one flagged by last. A request
// is taken into an input register, evaluated against the supervisor state,
// and its response items are then delivered one per cycle from the result
// register while the response port is ready; the first one is presented once
// the pass reaches the result register and can be taken at the following
// edge. The input register frees as soon as the result register is empty or
// its last item is being taken, so a new request is accepted every cycle
// while passes produce at most one item and the response port is ready;
// a pass with more items holds the next request until its last item is taken
// at the single response port. Configuration registers sit on the APB port at
// byte address 4*index and are to be written only while no pass is in flight.
module charger_supervisor_core (
   input  logic                              clock,
   input  logic                              reset,
   chgsup_req_if.sink                        req_bus,
   chgsup_rsp_if.source                      rsp_bus,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [chgsup_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                       pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready
);

   chgsup_pkg::cfg_type  cfg;
   chgsup_pkg::pass_type pass;
   logic                 free;

   chgsup_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   chgsup_pass u_pass (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .cfg     (cfg),
      .free    (free),
      .pass    (pass)
   );

   chgsup_out u_out (
      .clock   (clock),
      .reset   (reset),
      .pass    (pass),
      .free    (free),
      .rsp_bus (rsp_bus)
   );

endmodule
